FILE: rtl/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// shared types and constants for the sorted wakeup delay list
// ----------------------------------------------------------------------------
package sdl_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TICK_BITS = 32;

  localparam int TASK_W  = 4;
  localparam int FIELD_W = 32;
  localparam int OCC_W   = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic cmp;   // capture compare and match flags
    logic ins;   // qualified insert, shift toward the tail
    logic rem;   // qualified remove, shift toward the head
  } sdl_ctl_t;

endpackage

FILE: rtl/sdl_cell.sv
// ----------------------------------------------------------------------------
// sdl_cell
// one slot of the sorted list: holds a wake tick and task id, compares
// against the transaction key and shifts with its neighbors
// ----------------------------------------------------------------------------
module sdl_cell #(
  parameter int TICK_BITS = sdl_pkg::DEF_TICK_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sdl_pkg::sdl_ctl_t         ctl,
  input  logic                      vld,
  input  logic [TICK_BITS-1:0]      new_wake,
  input  logic [sdl_pkg::TASK_W-1:0] new_task,
  input  logic                      prev_le,
  input  logic [TICK_BITS-1:0]      prev_wake,
  input  logic [sdl_pkg::TASK_W-1:0] prev_task,
  input  logic [TICK_BITS-1:0]      next_wake,
  input  logic [sdl_pkg::TASK_W-1:0] next_task,
  input  logic                      hit_in,
  output logic [TICK_BITS-1:0]      wake,
  output logic [sdl_pkg::TASK_W-1:0] tid,
  output logic                      le,
  output logic                      hit_out
);

  logic mt;

  // match at this slot or any slot closer to the head
  assign hit_out = hit_in | mt;

  always_ff @(posedge clk) begin
    if (rst) begin
      le <= 1'b0;
      mt <= 1'b0;
    end else if (ctl.cmp) begin
      le <= vld && (wake <= new_wake);
      mt <= vld && (tid == new_task);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      if (prev_le) begin
        wake <= new_wake;
        tid  <= new_task;
      end else begin
        wake <= prev_wake;
        tid  <= prev_task;
      end
    end else if (ctl.rem && hit_out) begin
      wake <= next_wake;
      tid  <= next_task;
    end
  end

endmodule

FILE: rtl/sorted_wakeup_delay_list.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_delay_list
// task ids kept in ascending wake tick order in a chain of compare/shift cells
// ----------------------------------------------------------------------------
// sequence: accept, compare, shift, load; out_valid rises as the load state
//   writes the output register, and the next transaction is taken only after
//   that, with a single compare pass and single shift pass through the chain
// in_ready is high only in idle; a finished result waits in the output register
// reset: occupancy returns to zero and all control state clears; slot contents
//   are not cleared, since slots beyond the occupancy are never read
// ----------------------------------------------------------------------------
module sorted_wakeup_delay_list #(
  parameter int MAX_TASKS = sdl_pkg::DEF_MAX_TASKS,
  parameter int TICK_BITS = sdl_pkg::DEF_TICK_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [sdl_pkg::TASK_W-1:0]  task_id,
  input  logic [sdl_pkg::FIELD_W-1:0] sleep_ticks,
  input  logic [sdl_pkg::FIELD_W-1:0] current_tick,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        head_valid,
  output logic [sdl_pkg::TASK_W-1:0]  head_task,
  output logic [sdl_pkg::FIELD_W-1:0] head_wake,
  output logic [sdl_pkg::OCC_W-1:0]   occupancy
);

  import sdl_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_APPLY = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state, state_next;

  // captured transaction
  logic                 cmd_q;
  logic [TASK_W-1:0]    task_q;
  logic [TICK_BITS-1:0] wake_q;
  logic [TICK_BITS-1:0] cur_ext;
  logic [TICK_BITS-1:0] dly_ext;

  logic [CNT_W-1:0] count;
  status_t          st_q;
  status_t          st_next;

  sdl_ctl_t ctl;
  logic     full;
  logic     found;
  logic     in_fire;
  logic     out_load;

  // chain wiring
  logic [TICK_BITS-1:0] cell_wake [MAX_TASKS];
  logic [TASK_W-1:0]    cell_tid  [MAX_TASKS];
  logic [MAX_TASKS-1:0] cell_le;
  logic [MAX_TASKS-1:0] cell_vld;
  logic [MAX_TASKS:0]   hit_c;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // wake tick wraps modulo 2^TICK_BITS
  assign cur_ext = TICK_BITS'(current_tick);
  assign dly_ext = TICK_BITS'(sleep_ticks);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q  <= cmd;
      task_q <= task_id;
      wake_q <= cur_ext + dly_ext;
    end
  end

  // hit at the tail of the chain means the task is held somewhere
  assign hit_c[0] = 1'b0;
  assign found    = hit_c[MAX_TASKS];
  assign full     = (count == CNT_W'(MAX_TASKS));

  // full is checked before the duplicate test
  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      if (full)       st_next = ST_FULL;
      else if (found) st_next = ST_DUP;
      else            st_next = ST_OK;
    end else begin
      st_next = found ? ST_OK : ST_MISSING;
    end
  end

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = (state == S_APPLY) && (cmd_q == CMD_INSERT) && !full && !found;
    ctl.rem = (state == S_APPLY) && (cmd_q == CMD_REMOVE) && found;
  end

  // the cell chain
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic                 p_le;
    logic [TICK_BITS-1:0] p_wake;
    logic [TASK_W-1:0]    p_tid;
    logic [TICK_BITS-1:0] n_wake;
    logic [TASK_W-1:0]    n_tid;

    // slots below the occupancy are the live ones
    assign cell_vld[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      // head slot sees a virtual earlier entry that is always <= the key
      assign p_le   = 1'b1;
      assign p_wake = '0;
      assign p_tid  = '0;
    end else begin : g_body
      assign p_le   = cell_le[i-1];
      assign p_wake = cell_wake[i-1];
      assign p_tid  = cell_tid[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_tail
      // tail slot drops out of occupancy on remove, content is don't care
      assign n_wake = '0;
      assign n_tid  = '0;
    end else begin : g_mid
      assign n_wake = cell_wake[i+1];
      assign n_tid  = cell_tid[i+1];
    end

    sdl_cell #(
      .TICK_BITS(TICK_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .vld      (cell_vld[i]),
      .new_wake (wake_q),
      .new_task (task_q),
      .prev_le  (p_le),
      .prev_wake(p_wake),
      .prev_task(p_tid),
      .next_wake(n_wake),
      .next_task(n_tid),
      .hit_in   (hit_c[i]),
      .wake     (cell_wake[i]),
      .tid      (cell_tid[i]),
      .le       (cell_le[i]),
      .hit_out  (hit_c[i+1])
    );
  end

  // occupancy and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + 1'b1;
    end else if (ctl.rem) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      st_q <= st_next;
    end
  end

  // result register; load waits while a previous result is still pending
  assign out_load = (state == S_LOAD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= st_q;
      head_valid <= (count != '0);
      head_task  <= (count != '0) ? cell_tid[0] : '0;
      head_wake  <= (count != '0) ? FIELD_W'(cell_wake[0]) : '0;
      occupancy  <= OCC_W'(count);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: state_next = S_LOAD;
      S_LOAD:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("occupancy above capacity");

  a_ins_rem_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove in the same cycle");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count >= CNT_W'(2)) |-> cell_wake[0] <= cell_wake[1])
    else $error("head slots out of order");

  a_full_no_ins: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && full) |-> !ctl.ins)
    else $error("insert into a full list");

endmodule

FILE: test/sorted_wakeup_delay_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_wakeup_delay_list_tb
// self-checking bench for the sorted wakeup delay list
//
// a directed table walks the empty, wrap, duplicate, tie and full cases, then
// random fill and drain phases with random tick and delay values follow. a
// mirror of the list predicts status, head and occupancy for every accepted
// transaction, and each returned transaction is compared field by field
// against the oldest pending prediction. both sides idle at random; the
// receiver also holds off for a long stretch while transactions keep coming
// ----------------------------------------------------------------------------
module sorted_wakeup_delay_list_tb;
  import sdl_pkg::*;

  localparam int DIR_N       = 25;
  localparam int RAND_N      = 1200;
  localparam int HOLD_LEN    = 80;
  localparam int CYCLE_LIMIT = 400000;

  // what the block reports after one transaction
  typedef struct packed {
    status_t             status;
    logic                head_valid;
    logic [TASK_W-1:0]   head_task;
    logic [FIELD_W-1:0]  head_wake;
    logic [OCC_W-1:0]    occupancy;
  } list_view_t;

  // one row of the directed table; typed rows carry their own expected view
  typedef struct packed {
    logic                c;
    logic [TASK_W-1:0]   id;
    logic [FIELD_W-1:0]  dly;
    logic [FIELD_W-1:0]  now;
    logic                typed;
    list_view_t          want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_INSERT;
  logic [TASK_W-1:0]   task_id = '0;
  logic [FIELD_W-1:0]  sleep_ticks = '0;
  logic [FIELD_W-1:0]  current_tick = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic                head_valid;
  logic [TASK_W-1:0]   head_task;
  logic [FIELD_W-1:0]  head_wake;
  logic [OCC_W-1:0]    occupancy;

  // mirror of the list contents, slot 0 is the earliest waker
  logic [FIELD_W-1:0]  mirror_wake [DEF_MAX_TASKS];
  logic [TASK_W-1:0]   mirror_task [DEF_MAX_TASKS];
  int                  mirror_count = 0;

  list_view_t          pending_results [$];
  dir_row_t            dir_tab [DIR_N];
  int                  mismatches = 0;
  int                  cycles = 0;
  logic                calm = 1'b0;      // no idling on either side
  int                  hold_req = 0;     // bumped to ask the receiver for a hold-off
  int                  holds_done = 0;
  int                  hold_left = 0;

  sorted_wakeup_delay_list DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .task_id      (task_id),
    .sleep_ticks  (sleep_ticks),
    .current_tick (current_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .head_valid   (head_valid),
    .head_task    (head_task),
    .head_wake    (head_wake),
    .occupancy    (occupancy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // slot holding the task, or the occupancy when the task is not held
  function automatic int slot_of(input logic [TASK_W-1:0] id);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_task[i] == id) return i;
    end
    return mirror_count;
  endfunction

  // applies one transaction to the mirror and returns the view it produces
  function automatic list_view_t wake_list_update(input logic c,
                                                  input logic [TASK_W-1:0] id,
                                                  input logic [FIELD_W-1:0] dly,
                                                  input logic [FIELD_W-1:0] now);
    list_view_t          v;
    logic [FIELD_W-1:0]  wake;
    status_t             st;
    int                  at;
    int                  pos;
    wake = now + dly;  // wraps modulo 2^32
    at = slot_of(id);
    st = ST_OK;
    if (c == CMD_INSERT) begin
      // fullness wins over the duplicate check
      if (mirror_count >= DEF_MAX_TASKS) begin
        st = ST_FULL;
      end else if (at < mirror_count) begin
        st = ST_DUP;
      end else begin
        // equal wake ticks go behind the ones already held
        pos = 0;
        while (pos < mirror_count && mirror_wake[pos] <= wake) pos++;
        for (int i = mirror_count; i > pos; i--) begin
          mirror_wake[i] = mirror_wake[i-1];
          mirror_task[i] = mirror_task[i-1];
        end
        mirror_wake[pos] = wake;
        mirror_task[pos] = id;
        mirror_count++;
      end
    end else if (at >= mirror_count) begin
      st = ST_MISSING;
    end else begin
      for (int i = at; i + 1 < mirror_count; i++) begin
        mirror_wake[i] = mirror_wake[i+1];
        mirror_task[i] = mirror_task[i+1];
      end
      mirror_count--;
    end
    v.status     = st;
    v.head_valid = (mirror_count > 0);
    v.head_task  = (mirror_count > 0) ? mirror_task[0] : '0;
    v.head_wake  = (mirror_count > 0) ? mirror_wake[0] : '0;
    v.occupancy  = OCC_W'(mirror_count);
    return v;
  endfunction

  // offers one transaction, holds it until accepted, then logs its prediction
  task automatic offer(input logic c, input logic [TASK_W-1:0] id,
                       input logic [FIELD_W-1:0] dly, input logic [FIELD_W-1:0] now,
                       input logic typed, input list_view_t want);
    list_view_t pred;
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    task_id      <= id;
    sleep_ticks  <= dly;
    current_tick <= now;
    do @(posedge clk); while (!in_ready);
    // the mirror moves on every accepted transaction, typed rows included
    pred = wake_list_update(c, id, dly, now);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // receiver: checks each returned transaction, then picks the next ready
  always @(posedge clk) begin
    list_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with nothing pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("status",     FIELD_W'(want.status),     FIELD_W'(status));
        compare_field("head_valid", FIELD_W'(want.head_valid), FIELD_W'(head_valid));
        compare_field("head_task",  FIELD_W'(want.head_task),  FIELD_W'(head_task));
        compare_field("head_wake",  want.head_wake,            head_wake);
        compare_field("occupancy",  FIELD_W'(want.occupancy),  FIELD_W'(occupancy));
      end
    end
    // long hold-off counted here so the sender keeps pushing into a stalled block
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != holds_done) begin
      holds_done <= hold_req;
      hold_left  <= HOLD_LEN;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic                c;
    logic [TASK_W-1:0]   id;
    logic [FIELD_W-1:0]  dly;
    logic [FIELD_W-1:0]  tick_now;
    int                  r;
    logic                filling;

    // directed table: empty list, extremes, wrap, ties, duplicate, full
    dir_tab = '{
      // remove from an empty list
      '{CMD_REMOVE, 4'd5,  32'd0,          32'd0,          1'b1,
        '{ST_MISSING, 1'b0, 4'd0, 32'd0, 5'd0}},
      '{CMD_INSERT, 4'd0,  32'd0,          32'd0,          1'b1,
        '{ST_OK, 1'b1, 4'd0, 32'd0, 5'd1}},
      // largest delay and tick, wake wraps to all ones minus one
      '{CMD_INSERT, 4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
        '{ST_OK, 1'b1, 4'd0, 32'd0, 5'd2}},
      '{CMD_INSERT, 4'd0,  32'd1234,       32'd9,          1'b1,
        '{ST_DUP, 1'b1, 4'd0, 32'd0, 5'd2}},
      // wake wraps around to 2, then a tie on 2
      '{CMD_INSERT, 4'd7,  32'd5,          32'hFFFF_FFFD,  1'b0, '0},
      '{CMD_INSERT, 4'd3,  32'd2,          32'd0,          1'b0, '0},
      '{CMD_REMOVE, 4'd3,  32'd0,          32'd0,          1'b0, '0},
      '{CMD_REMOVE, 4'd9,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '0},
      // fill to capacity, with ties on the head, in the middle and next to the tail
      '{CMD_INSERT, 4'd1,  32'd0,          32'd0,          1'b0, '0},
      '{CMD_INSERT, 4'd2,  32'h8000_0000,  32'h0000_0001,  1'b0, '0},
      '{CMD_INSERT, 4'd3,  32'd2,          32'd0,          1'b0, '0},
      '{CMD_INSERT, 4'd4,  32'hFFFF_FFFE,  32'd0,          1'b0, '0},
      '{CMD_INSERT, 4'd5,  32'h5555_5555,  32'hAAAA_AAAA,  1'b0, '0},
      '{CMD_INSERT, 4'd6,  32'd100,        32'd1000,       1'b0, '0},
      '{CMD_INSERT, 4'd8,  32'h0000_FFFF,  32'h0001_0000,  1'b0, '0},
      '{CMD_INSERT, 4'd9,  32'd7,          32'hFFFF_FFFC,  1'b0, '0},
      '{CMD_INSERT, 4'd10, 32'h1234_5678,  32'h8765_4321,  1'b0, '0},
      '{CMD_INSERT, 4'd11, 32'hFFFF_FFFF,  32'd1,          1'b0, '0},
      '{CMD_INSERT, 4'd12, 32'd1,          32'h7FFF_FFFF,  1'b0, '0},
      '{CMD_INSERT, 4'd13, 32'hF0F0_F0F0,  32'h0F0F_0F0E,  1'b0, '0},
      '{CMD_INSERT, 4'd14, 32'hDEAD_BEEF,  32'd0,          1'b0, '0},
      // full list, inserting two tasks that are already held
      '{CMD_INSERT, 4'd3,  32'd0,          32'd0,          1'b1,
        '{ST_FULL, 1'b1, 4'd0, 32'd0, 5'd16}},
      '{CMD_INSERT, 4'd0,  32'd0,          32'd0,          1'b1,
        '{ST_FULL, 1'b1, 4'd0, 32'd0, 5'd16}},
      // remove the head, then the tail
      '{CMD_REMOVE, 4'd0,  32'd0,          32'd0,          1'b0, '0},
      '{CMD_REMOVE, 4'd5,  32'd0,          32'd0,          1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_N; n++) begin
      offer(dir_tab[n].c, dir_tab[n].id, dir_tab[n].dly, dir_tab[n].now,
            dir_tab[n].typed, dir_tab[n].want);
    end

    // random part: alternating fill and drain phases of mostly legal traffic
    tick_now = $urandom;
    for (int n = 0; n < RAND_N; n++) begin
      if (n == 300) hold_req <= hold_req + 1;
      if (n == 500) calm <= 1'b1;
      if (n == 700) calm <= 1'b0;
      if (n == 850) begin
        // let everything in flight come back before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end

      // kernel tick mostly creeps forward, sometimes jumps or sits near wrap
      case ($urandom_range(15))
        0:       tick_now = $urandom;
        1:       tick_now = 32'hFFFF_FFF0 + $urandom_range(15);
        default: tick_now = tick_now + $urandom_range(2);
      endcase
      case ($urandom_range(3))
        0:       dly = $urandom_range(15);
        1:       dly = $urandom;
        2:       dly = 32'hFFFF_FFFF - $urandom_range(7);
        default: dly = $urandom_range(1000);
      endcase

      filling = ((n / 48) % 2 == 0);
      r = $urandom_range(99);
      if (r < 8) begin
        // noise: anything goes, including duplicates and absent removes
        c = 1'($urandom_range(1));
        id = TASK_W'($urandom_range(15));
        dly = $urandom;
        tick_now = $urandom;
      end else if (filling ? (r < 78) : (r < 32)) begin
        c = CMD_INSERT;
        id = TASK_W'($urandom_range(15));
        if (mirror_count < DEF_MAX_TASKS) begin
          while (slot_of(id) < mirror_count) id = id + 1'b1;
        end
      end else begin
        c = CMD_REMOVE;
        if (mirror_count > 0) id = mirror_task[$urandom_range(mirror_count - 1)];
        else id = TASK_W'($urandom_range(15));
      end
      offer(c, id, dly, tick_now, 1'b0, '0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    // then idle on to catch any stray result
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
